>>> sv/id3tp_pkg.sv
// Shared types, codes and constants of the ID3v2 text frame parser.
package id3tp_pkg;

  localparam int MAX_TEXT_LEN_DEF = 256;
  localparam int AREA_W           = 28;

  typedef enum logic [5:0] {
    PH_HEADER    = 6'b000001,
    PH_EXTSIZE   = 6'b000010,
    PH_EXTSKIP   = 6'b000100,
    PH_FRAMEHDR  = 6'b001000,
    PH_FRAMEDATA = 6'b010000,
    PH_DONE      = 6'b100000
  } id3tp_phase_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_MARKER   = 2'd1,
    ST_BAD_VERSION = 2'd2,
    ST_EARLY_END   = 2'd3
  } id3tp_status_t;

  localparam logic [1:0] FLD_ARTIST = 2'd0;
  localparam logic [1:0] FLD_TITLE  = 2'd1;
  localparam logic [1:0] FLD_ALBUM  = 2'd2;
  localparam logic [1:0] FLD_NONE   = 2'd3;

  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_3      = 8'h33;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_Z      = 8'h5A;
  localparam logic [7:0] MAX_MAJOR = 8'd4;
  localparam logic [7:0] ENC_LATIN = 8'd0;
  localparam logic [7:0] ENC_UTF8  = 8'd3;

  localparam logic [31:0] ID_TPE1   = 32'h54504531;
  localparam logic [31:0] ID_TPE2   = 32'h54504532;
  localparam logic [31:0] ID_TPE3   = 32'h54504533;
  localparam logic [31:0] ID_TIT2   = 32'h54495432;
  localparam logic [31:0] ID_TALB   = 32'h54414C42;
  localparam logic [31:0] ID22_TPE  = 32'h00545045;
  localparam logic [31:0] ID22_TIT  = 32'h00544954;

  typedef struct packed {
    logic       valid;
    logic [7:0] tag_byte;
    logic       last_byte;
  } id3tp_item_t;

  typedef struct packed {
    logic       text_valid;
    logic [7:0] text_byte;
    logic [1:0] text_field;
    logic       field_end;
    logic       tag_end;
    logic [1:0] status;
  } id3tp_result_t;

  function automatic logic [1:0] match_field(input logic v22, input logic [31:0] id);
    logic [1:0] f;
    f = FLD_NONE;
    if (v22) begin
      if (id == ID22_TPE) f = FLD_ARTIST;
      else if (id == ID22_TIT) f = FLD_TITLE;
    end else begin
      if (id == ID_TPE1 || id == ID_TPE2 || id == ID_TPE3) f = FLD_ARTIST;
      else if (id == ID_TIT2) f = FLD_TITLE;
      else if (id == ID_TALB) f = FLD_ALBUM;
    end
    return f;
  endfunction

endpackage

>>> sv/id3tp_if.sv
// Byte input and text result channel interfaces.
interface id3tp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] tag_byte;
  logic       last_byte;
  modport source (output valid, tag_byte, last_byte, input ready);
  modport sink (input valid, tag_byte, last_byte, output ready);
endinterface

interface id3tp_out_if;
  logic       valid;
  logic       ready;
  logic       text_valid;
  logic [7:0] text_byte;
  logic [1:0] text_field;
  logic       field_end;
  logic       tag_end;
  logic [1:0] status;
  modport source (output valid, text_valid, text_byte, text_field, field_end, tag_end,
                  status, input ready);
  modport sink (input valid, text_valid, text_byte, text_field, field_end, tag_end,
                status, output ready);
endinterface

>>> sv/id3tp_in_reg.sv
// Input register holding one file byte beat ahead of the parser.
module id3tp_in_reg
  import id3tp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  id3tp_in_if.sink          in_bus,
  input  logic              consume,
  output id3tp_item_t       item
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       take;

  assign in_bus.ready = !valid_r || consume;
  assign take         = in_bus.valid && in_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (consume) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_bus.tag_byte;
      last_r <= in_bus.last_byte;
    end
  end

  assign item = '{valid: valid_r, tag_byte: byte_r, last_byte: last_r};

endmodule

>>> sv/id3tp_core.sv
// Parser state and the per-byte step logic.
module id3tp_core
  import id3tp_pkg::*;
#(
  parameter int MAX_TEXT_LEN = MAX_TEXT_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  id3tp_item_t   item,
  output logic          res_hit,
  output id3tp_result_t res
);

  localparam int LEN_W = $clog2(MAX_TEXT_LEN + 1);
  localparam logic [31:0]      MAX32 = 32'(MAX_TEXT_LEN);
  localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_TEXT_LEN);

  id3tp_phase_t      phase_r, phase_nxt;
  logic [3:0]        hdr_idx_r, hdr_idx_nxt;
  logic [AREA_W-1:0] didx_r, didx_nxt;
  logic              v22_r, v22_nxt;
  logic              ext_r, ext_nxt;
  logic [AREA_W-1:0] area_r, area_nxt;     // tag size, then bytes left in the frame area
  logic [31:0]       skip_r, skip_nxt;
  logic [31:0]       ident_r, ident_nxt;
  logic [31:0]       flen_r, flen_nxt;
  logic              raw_r, raw_nxt;
  logic              emitted_r, emitted_nxt;
  logic [2:0]        captured_r, captured_nxt;
  logic [1:0]        sel_r, sel_nxt;

  logic [7:0]        b;
  logic [3:0]        k;
  logic [3:0]        hdr_len;
  logic [3:0]        id_len;
  logic              nf;
  logic [AREA_W-1:0] nf_rem;
  logic [31:0]       ext_acc;
  logic [31:0]       ext_x;
  logic [31:0]       skip_dec;
  logic [1:0]        sel_m;
  logic              t_valid, t_fend, t_end;
  logic [1:0]        t_stat;

  // text window for the current frame
  logic [LEN_W-1:0]  raw_lim, utf_n;
  logic [31:0]       half_sz;
  logic [AREA_W-1:0] half_idx;
  logic              raw_emit, raw_last, utf_emit, utf_last, do_emit, emit_last;

  assign b       = item.tag_byte;
  assign k       = hdr_idx_r;
  assign hdr_len = v22_r ? 4'd6 : 4'd10;
  assign id_len  = v22_r ? 4'd3 : 4'd4;
  assign ext_acc = {skip_r[23:0], b};
  assign ext_x   = (ext_acc < 32'd4) ? 32'd4 : ext_acc;
  assign skip_dec = skip_r - {31'd0, (skip_r != 32'd0)};
  assign sel_m   = match_field(v22_r, ident_r);

  assign raw_lim  = (flen_r < MAX32) ? flen_r[LEN_W-1:0] : MAX_L;
  assign raw_emit = (didx_r != '0) && (didx_r < AREA_W'(raw_lim));
  assign raw_last = (didx_r == AREA_W'(raw_lim) - AREA_W'(1));
  assign half_sz  = (flen_r - 32'd3) >> 1;
  assign utf_n    = (half_sz < MAX32) ? half_sz[LEN_W-1:0] : MAX_L;
  assign half_idx = (didx_r - AREA_W'(3)) >> 1;
  // UTF-16 takes the low byte of every unit: odd data offsets from 3 on
  assign utf_emit = (flen_r >= 32'd3) && (didx_r >= AREA_W'(3)) && didx_r[0]
                    && (half_idx < AREA_W'(utf_n));
  assign utf_last = (half_idx == AREA_W'(utf_n) - AREA_W'(1));
  // encoding byte sits at offset 0, where neither form emits, so raw_r is current
  assign do_emit   = raw_r ? raw_emit : utf_emit;
  assign emit_last = raw_r ? raw_last : utf_last;

  always_comb begin
    phase_nxt    = phase_r;
    hdr_idx_nxt  = hdr_idx_r;
    didx_nxt     = didx_r;
    v22_nxt      = v22_r;
    ext_nxt      = ext_r;
    area_nxt     = area_r;
    skip_nxt     = skip_r;
    ident_nxt    = ident_r;
    flen_nxt     = flen_r;
    raw_nxt      = raw_r;
    emitted_nxt  = emitted_r;
    captured_nxt = captured_r;
    sel_nxt      = sel_r;
    nf           = 1'b0;
    nf_rem       = area_r;
    t_valid      = 1'b0;
    t_fend       = 1'b0;
    t_end        = 1'b0;
    t_stat       = ST_OK;

    if (step_en) begin
      unique case (phase_r)
        PH_HEADER: begin
          hdr_idx_nxt = k + 4'd1;
          if ((k == 4'd0 && b != CH_I) || (k == 4'd1 && b != CH_D) ||
              (k == 4'd2 && b != CH_3)) begin
            phase_nxt = PH_DONE;
            t_end     = 1'b1;
            t_stat    = ST_NO_MARKER;
          end else if (k == 4'd3 && b > MAX_MAJOR) begin
            phase_nxt = PH_DONE;
            t_end     = 1'b1;
            t_stat    = ST_BAD_VERSION;
          end else begin
            if (k == 4'd3) v22_nxt = (b < 8'd3);
            if (k == 4'd5) ext_nxt = b[6];
            if (k >= 4'd6) area_nxt = {area_r[AREA_W-8:0], b[6:0]};
            if (k == 4'd9) begin
              if (ext_r) begin
                phase_nxt   = PH_EXTSIZE;
                hdr_idx_nxt = 4'd0;
                skip_nxt    = 32'd0;
              end else begin
                nf     = 1'b1;
                nf_rem = area_nxt;
              end
            end
          end
        end
        PH_EXTSIZE: begin
          skip_nxt    = ext_acc;
          hdr_idx_nxt = k + 4'd1;
          if (k == 4'd3) begin
            area_nxt = (ext_x >= {{(32-AREA_W){1'b0}}, area_r}) ? '0
                       : area_r - ext_x[AREA_W-1:0];
            skip_nxt = ext_x - 32'd4;
            if (ext_x == 32'd4) begin
              nf     = 1'b1;
              nf_rem = area_nxt;
            end else begin
              phase_nxt = PH_EXTSKIP;
            end
          end
        end
        PH_EXTSKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 32'd0) nf = 1'b1;
        end
        PH_FRAMEHDR: begin
          if (k == 4'd0 && (b < CH_A || b > CH_Z)) begin
            // padding
            phase_nxt = PH_DONE;
            t_end     = 1'b1;
          end else begin
            if (k < id_len) begin
              ident_nxt = (k == 4'd0) ? {24'd0, b} : {ident_r[23:0], b};
            end else if (k < {id_len[2:0], 1'b0}) begin
              flen_nxt = (k == id_len) ? {24'd0, b} : {flen_r[23:0], b};
            end
            area_nxt    = area_r - AREA_W'(1);
            hdr_idx_nxt = k + 4'd1;
            if (k == hdr_len - 4'd1) begin
              if (flen_nxt > {{(32-AREA_W){1'b0}}, area_nxt}) begin
                phase_nxt = PH_DONE;
                t_end     = 1'b1;
              end else begin
                sel_nxt     = (sel_m != FLD_NONE && captured_r[sel_m]) ? FLD_NONE : sel_m;
                emitted_nxt = 1'b0;
                didx_nxt    = '0;
                hdr_idx_nxt = 4'd0;
                skip_nxt    = flen_nxt;
                if (flen_nxt == 32'd0) begin
                  nf     = 1'b1;
                  nf_rem = area_nxt;
                end else begin
                  phase_nxt = PH_FRAMEDATA;
                end
              end
            end
          end
        end
        PH_FRAMEDATA: begin
          if (didx_r == '0) raw_nxt = (b == ENC_LATIN) || (b == ENC_UTF8);
          if (sel_r != FLD_NONE && do_emit) begin
            t_valid     = 1'b1;
            t_fend      = emit_last;
            emitted_nxt = 1'b1;
            if (!emitted_r && b != 8'd0) captured_nxt[sel_r] = 1'b1;
          end
          area_nxt = area_r - AREA_W'(1);
          didx_nxt = didx_r + AREA_W'(1);
          skip_nxt = skip_dec;
          if (skip_dec == 32'd0) begin
            nf     = 1'b1;
            nf_rem = area_nxt;
          end
        end
        PH_DONE: begin
        end
        default: phase_nxt = PH_DONE;
      endcase

      if (nf) begin
        if (nf_rem < AREA_W'(hdr_len)) begin
          phase_nxt = PH_DONE;
          t_end     = 1'b1;
          t_stat    = ST_OK;
        end else begin
          phase_nxt   = PH_FRAMEHDR;
          hdr_idx_nxt = 4'd0;
        end
      end

      if (item.last_byte) begin
        if (phase_r != PH_DONE && !t_end) begin
          t_end  = 1'b1;
          t_stat = ST_EARLY_END;
        end
        phase_nxt    = PH_HEADER;
        hdr_idx_nxt  = 4'd0;
        didx_nxt     = '0;
        v22_nxt      = 1'b1;
        ext_nxt      = 1'b0;
        area_nxt     = '0;
        skip_nxt     = 32'd0;
        ident_nxt    = 32'd0;
        flen_nxt     = 32'd0;
        raw_nxt      = 1'b1;
        emitted_nxt  = 1'b0;
        captured_nxt = 3'b000;
        sel_nxt      = FLD_NONE;
      end
    end
  end

  assign res_hit = t_valid || t_end;
  assign res = '{text_valid: t_valid,
                 text_byte:  t_valid ? b : 8'd0,
                 text_field: t_valid ? sel_r : FLD_ARTIST,
                 field_end:  t_fend,
                 tag_end:    t_end,
                 status:     t_stat};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hdr_idx_r  <= 4'd0;
      didx_r     <= '0;
      v22_r      <= 1'b1;   // major version zero
      ext_r      <= 1'b0;
      area_r     <= '0;
      skip_r     <= 32'd0;
      ident_r    <= 32'd0;
      flen_r     <= 32'd0;
      raw_r      <= 1'b1;   // encoding zero
      emitted_r  <= 1'b0;
      captured_r <= 3'b000;
      sel_r      <= FLD_NONE;
    end else begin
      phase_r    <= phase_nxt;
      hdr_idx_r  <= hdr_idx_nxt;
      didx_r     <= didx_nxt;
      v22_r      <= v22_nxt;
      ext_r      <= ext_nxt;
      area_r     <= area_nxt;
      skip_r     <= skip_nxt;
      ident_r    <= ident_nxt;
      flen_r     <= flen_nxt;
      raw_r      <= raw_nxt;
      emitted_r  <= emitted_nxt;
      captured_r <= captured_nxt;
      sel_r      <= sel_nxt;
    end
  end

  a_text_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && t_valid |-> phase_r == PH_FRAMEDATA && sel_r != FLD_NONE)
    else $error("text beat outside a selected frame");

  a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && item.last_byte |=> phase_r == PH_HEADER && hdr_idx_r == 4'd0)
    else $error("parser not rearmed after last byte");

  a_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && t_end |=> phase_r == PH_DONE || phase_r == PH_HEADER)
    else $error("walk continues after tag end");

  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && phase_r == PH_DONE && !item.last_byte |-> !res_hit)
    else $error("result after tag end");

endmodule

>>> sv/id3tp_out_reg.sv
// Result register driving the text output channel.
module id3tp_out_reg
  import id3tp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  id3tp_result_t res,
  output logic          room,
  id3tp_out_if.source   out_bus
);

  logic          valid_r;
  id3tp_result_t res_r;

  assign room = !valid_r || out_bus.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res;
  end

  assign out_bus.valid      = valid_r;
  assign out_bus.text_valid = res_r.text_valid;
  assign out_bus.text_byte  = res_r.text_byte;
  assign out_bus.text_field = res_r.text_field;
  assign out_bus.field_end  = res_r.field_end;
  assign out_bus.tag_end    = res_r.tag_end;
  assign out_bus.status     = res_r.status;

endmodule

>>> sv/id3v2_text_frame_parser.sv
// Top level of the ID3v2 text frame parser.
//
// in_bus carries the file one byte per beat, from its first byte, with
// last_byte set on the final byte. out_bus carries a beat only when the
// byte produced something: a text character (text_valid, with text_field
// naming artist, title or album and field_end on its last character) and/or
// tag_end with a status code once the header or frame walk has finished.
// After tag_end the rest of the file is swallowed without results; the
// beat with last_byte rearms the parser for the next file.
// An accepted byte is held in the input register, then parsed by the
// combinational core into the result register once that has room.
// One byte per cycle is sustained while out_bus is not stalled; the rate
// is set by the single parse step between the two registers.
// A stalled result holds in the output register while the input register
// still takes one more byte; further bytes wait until out_bus.ready rises.
// Reset (rst_n low at a clock edge) empties both registers and returns the
// parser to the start of a file.
module id3v2_text_frame_parser
  import id3tp_pkg::*;
#(
  parameter int MAX_TEXT_LEN = MAX_TEXT_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  id3tp_in_if.sink    in_bus,
  id3tp_out_if.source out_bus
);

  id3tp_item_t   item;
  id3tp_result_t res;
  logic          res_hit;
  logic          room;
  logic          advance;

  assign advance = item.valid && room;

  id3tp_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .consume (advance),
    .item    (item)
  );

  id3tp_core #(
    .MAX_TEXT_LEN (MAX_TEXT_LEN)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item),
    .res_hit (res_hit),
    .res     (res)
  );

  id3tp_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (advance && res_hit),
    .res     (res),
    .room    (room),
    .out_bus (out_bus)
  );

endmodule

>>> sim/tb_id3v2_text_frame_parser.sv
// Testbench for id3v2_text_frame_parser: directed byte table, random tag files, result scoreboard.
`timescale 1ns / 1ps

module tb_id3v2_text_frame_parser
  import id3tp_pkg::*;
();

  localparam int          TEXT_CAP       = MAX_TEXT_LEN_DEF;
  localparam int          SMALL_ITEMS    = 850;
  localparam logic [7:0]  ENC_UTF16_BOM  = 8'd1;
  localparam logic [7:0]  ENC_UTF16_BE   = 8'd2;
  localparam logic [31:0] ID22_TAL       = 32'h0054414C;

  typedef struct {
    logic [7:0]    b;
    logic          last;
    bit            typed;
    bit            has;
    id3tp_result_t res;
  } byte_row_t;

  logic clk;
  logic rst_n;

  id3tp_in_if  in_bus ();
  id3tp_out_if out_bus ();

  id3v2_text_frame_parser u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  // parser image
  id3tp_phase_t  ph;
  int unsigned   cnt;
  int unsigned   major;
  bit            ext_on;
  logic [31:0]   area, pos, skip, ident, flen;
  logic [7:0]    enc;
  int unsigned   nchars;
  logic [2:0]    got;
  logic [1:0]    sel;
  id3tp_result_t pred;

  id3tp_result_t text_q[$];
  byte_row_t     rows[$];
  logic [7:0]    file_q[$];
  logic [7:0]    body_q[$];
  logic [7:0]    data_q[$];

  int            n_fail;
  int            n_sent;
  int            gen_major;
  int            rx_hold;
  bit            tx_burst, rx_burst;
  bit            cur_typed, cur_has;
  id3tp_result_t cur_res;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned hdr_len();
    return (major < 3) ? 6 : 10;
  endfunction

  task clear_parser();
    ph     = PH_HEADER;
    cnt    = 0;
    major  = 0;
    ext_on = 1'b0;
    area   = '0;
    pos    = '0;
    skip   = '0;
    ident  = '0;
    flen   = '0;
    enc    = '0;
    nchars = 0;
    got    = '0;
    sel    = FLD_NONE;
  endtask

  task stop_walk(input id3tp_status_t code);
    ph           = PH_DONE;
    pred.tag_end = 1'b1;
    pred.status  = code;
  endtask

  task next_frame_or_stop();
    if (area - pos < hdr_len()) begin
      stop_walk(ST_OK);
    end else begin
      ph  = PH_FRAMEHDR;
      cnt = 0;
    end
  endtask

  task parse_byte(input logic [7:0] b, input logic last, output bit hit);
    bit          was_done;
    bit          emit, fin;
    int unsigned k, idl, lim;
    logic [31:0] x, n;
    was_done = (ph == PH_DONE);
    pred     = '0;
    case (ph)
      PH_HEADER: begin
        k = cnt;
        cnt++;
        if ((k == 0 && b != CH_I) || (k == 1 && b != CH_D) || (k == 2 && b != CH_3)) begin
          stop_walk(ST_NO_MARKER);
        end else if (k == 3 && b > MAX_MAJOR) begin
          stop_walk(ST_BAD_VERSION);
        end else begin
          if (k == 3) major = b;
          if (k == 5) ext_on = b[6];
          if (k >= 6) area = {4'h0, area[20:0], b[6:0]};
          if (k == 9) begin
            pos = '0;
            if (ext_on) begin
              ph   = PH_EXTSIZE;
              cnt  = 0;
              skip = '0;
            end else begin
              next_frame_or_stop();
            end
          end
        end
      end
      PH_EXTSIZE: begin
        skip = {skip[23:0], b};
        cnt++;
        if (cnt >= 4) begin
          // size counts its own four bytes, floor of four
          x    = (skip < 4) ? 32'd4 : skip;
          area = (x >= area) ? '0 : area - x;
          skip = x - 4;
          if (skip == 0) next_frame_or_stop();
          else ph = PH_EXTSKIP;
        end
      end
      PH_EXTSKIP: begin
        if (skip > 0) skip--;
        if (skip == 0) next_frame_or_stop();
      end
      PH_FRAMEHDR: begin
        idl = (major < 3) ? 3 : 4;
        k   = cnt;
        if (k == 0 && (b < CH_A || b > CH_Z)) begin
          stop_walk(ST_OK);  // padding
        end else begin
          if (k < idl) ident = (k == 0) ? {24'h0, b} : {ident[23:0], b};
          else if (k < 2 * idl) flen = (k == idl) ? {24'h0, b} : {flen[23:0], b};
          pos++;
          cnt++;
          if (cnt >= hdr_len()) begin
            if (flen > area - pos) begin
              stop_walk(ST_OK);
            end else begin
              if (major < 3) begin
                if (ident == ID22_TPE) sel = FLD_ARTIST;
                else if (ident == ID22_TIT) sel = FLD_TITLE;
                else sel = FLD_NONE;
              end else begin
                if (ident == ID_TPE1 || ident == ID_TPE2 || ident == ID_TPE3) sel = FLD_ARTIST;
                else if (ident == ID_TIT2) sel = FLD_TITLE;
                else if (ident == ID_TALB) sel = FLD_ALBUM;
                else sel = FLD_NONE;
              end
              if (sel != FLD_NONE && got[sel]) sel = FLD_NONE;
              nchars = 0;
              cnt    = 0;
              skip   = flen;
              if (flen == 0) next_frame_or_stop();
              else ph = PH_FRAMEDATA;
            end
          end
        end
      end
      PH_FRAMEDATA: begin
        if (cnt == 0) enc = b;
        if (sel != FLD_NONE) begin
          emit = 1'b0;
          fin  = 1'b0;
          if (enc == ENC_LATIN || enc == ENC_UTF8) begin
            lim = (flen < TEXT_CAP) ? flen : TEXT_CAP;
            if (cnt >= 1 && cnt < lim) begin
              emit = 1'b1;
              fin  = (cnt == lim - 1);
            end
          end else if (flen >= 3) begin
            // UTF-16: low byte of each unit after the BOM
            n = (flen - 3) / 2;
            if (n > TEXT_CAP) n = TEXT_CAP;
            if (cnt >= 3 && (cnt - 3) % 2 == 0 && (cnt - 3) / 2 < n) begin
              emit = 1'b1;
              fin  = ((cnt - 3) / 2 == n - 1);
            end
          end
          if (emit) begin
            pred.text_valid = 1'b1;
            pred.text_byte  = b;
            pred.text_field = sel;
            pred.field_end  = fin;
            if (nchars == 0 && b != 8'h00) got[sel] = 1'b1;
            nchars++;
          end
        end
        pos++;
        cnt++;
        if (skip > 0) skip--;
        if (skip == 0) next_frame_or_stop();
      end
      default: ph = PH_DONE;
    endcase
    if (last) begin
      if (!was_done && !pred.tag_end) begin
        pred.tag_end = 1'b1;
        pred.status  = ST_EARLY_END;
      end
      clear_parser();
    end
    hit = pred.text_valid || pred.tag_end;
  endtask

  task check_field(input string name, input int unsigned want, input int unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      n_fail++;
    end
  endtask

  // both handshakes sampled on the rising edge; byte side first
  always @(posedge clk) begin
    bit            hit;
    id3tp_result_t want;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        parse_byte(in_bus.tag_byte, in_bus.last_byte, hit);
        want = pred;
        if (cur_typed) begin
          hit  = cur_has;
          want = cur_res;
        end
        if (hit) text_q.push_back(want);
      end
      if (out_bus.valid && out_bus.ready) begin
        if (text_q.size() == 0) begin
          $error("result beat with nothing pending: text_byte %0h tag_end %0b",
                 out_bus.text_byte, out_bus.tag_end);
          n_fail++;
        end else begin
          want = text_q.pop_front();
          check_field("text_valid", want.text_valid, out_bus.text_valid);
          check_field("text_byte", want.text_byte, out_bus.text_byte);
          check_field("text_field", want.text_field, out_bus.text_field);
          check_field("field_end", want.field_end, out_bus.field_end);
          check_field("tag_end", want.tag_end, out_bus.tag_end);
          check_field("status", want.status, out_bus.status);
        end
        rx_hold = rx_burst ? 0 : $urandom_range(0, 7);
      end
    end
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_bus.ready <= 1'b0;
      rx_hold--;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  function automatic id3tp_result_t stop_res(input id3tp_status_t code);
    id3tp_result_t r;
    r         = '0;
    r.tag_end = 1'b1;
    r.status  = code;
    return r;
  endfunction

  task row_exp(input logic [7:0] b, input logic last, input bit has, input id3tp_result_t r);
    byte_row_t e;
    e.b     = b;
    e.last  = last;
    e.typed = 1'b1;
    e.has   = has;
    e.res   = r;
    rows.push_back(e);
  endtask

  task row_chk(input logic [7:0] b, input logic last);
    byte_row_t e;
    e.b     = b;
    e.last  = last;
    e.typed = 1'b0;
    e.has   = 1'b0;
    e.res   = '0;
    rows.push_back(e);
  endtask

  // called at a falling edge; returns at the falling edge after the beat
  task send_byte(input logic [7:0] b, input logic last, input bit typed, input bit has,
                 input id3tp_result_t r);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.tag_byte  <= b;
    in_bus.last_byte <= last;
    cur_typed        <= typed;
    cur_has          <= has;
    cur_res          <= r;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
    n_sent++;
  endtask

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] rnd_letter();
    return 8'($urandom_range(CH_A, CH_Z));
  endfunction

  task put_be(input logic [31:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) body_q.push_back(v[8*i +: 8]);
  endtask

  task make_text(input int len, input int enc_sel);
    logic [7:0] e;
    bit         zero_first;
    logic [7:0] ch;
    data_q.delete();
    if (enc_sel >= 0) begin
      e = 8'(enc_sel);
    end else begin
      case ($urandom_range(0, 5))
        1:       e = ENC_UTF8;
        2:       e = ENC_UTF16_BOM;
        3:       e = ENC_UTF16_BE;
        4:       e = rnd_byte();
        default: e = ENC_LATIN;
      endcase
    end
    data_q.push_back(e);
    zero_first = ($urandom_range(0, 5) == 0);
    if (e != ENC_LATIN && e != ENC_UTF8) begin
      data_q.push_back(8'hFF);
      data_q.push_back(8'hFE);
    end
    for (int i = 0; i < len; i++) begin
      if (i == 0 && zero_first) ch = 8'h00;
      else if ($urandom_range(0, 3) == 0) ch = rnd_byte();
      else ch = rnd_letter();
      data_q.push_back(ch);
      if (e != ENC_LATIN && e != ENC_UTF8)
        data_q.push_back(($urandom_range(0, 7) == 0) ? rnd_byte() : 8'h00);
    end
    if (e != ENC_LATIN && e != ENC_UTF8 && $urandom_range(0, 1) == 1)
      data_q.push_back(rnd_byte());
  endtask

  task add_frame(input logic [31:0] id, input int bump);
    int idw;
    idw = (gen_major < 3) ? 3 : 4;
    put_be(id, idw);
    put_be(data_q.size() + bump, idw);
    if (idw == 4) begin
      body_q.push_back(rnd_byte());
      body_q.push_back(rnd_byte());
    end
    foreach (data_q[i]) body_q.push_back(data_q[i]);
  endtask

  task build_file(input bit big);
    bit          ext_flag;
    logic [31:0] esize, x, id, fsize;
    int          nfr, keep;
    file_q.delete();
    body_q.delete();
    if (!big && $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) file_q.push_back(rnd_byte());
      return;
    end
    if (big) gen_major = 4;
    else if ($urandom_range(0, 15) == 0) gen_major = $urandom_range(5, 255);
    else gen_major = $urandom_range(0, 4);
    ext_flag = !big && ($urandom_range(0, 3) == 0);

    if (ext_flag) begin
      case ($urandom_range(0, 15))
        0:          esize = $urandom;
        1, 2, 3, 4: esize = $urandom_range(0, 3);
        default:    esize = $urandom_range(4, 12);
      endcase
      put_be(esize, 4);
      x = (esize < 4) ? 32'd4 : esize;
      // an oversized extended header just swallows the rest of the file
      if (x < 64) repeat (x - 4) body_q.push_back(rnd_byte());
    end

    if (big) begin
      make_text(257, ENC_LATIN);
      add_frame(ID_TIT2, 0);
    end else begin
      nfr = $urandom_range(0, 4);
      for (int f = 0; f < nfr; f++) begin
        if (gen_major >= 3) begin
          case ($urandom_range(0, 7))
            0:       id = ID_TPE1;
            1:       id = ID_TPE2;
            2:       id = ID_TPE3;
            3:       id = ID_TIT2;
            4:       id = ID_TALB;
            5:       id = {ID_TPE1[31:8], 8'h30 + 8'($urandom_range(4, 9))};
            default: id = {rnd_letter(), rnd_letter(), rnd_letter(), rnd_letter()};
          endcase
        end else begin
          case ($urandom_range(0, 6))
            0, 1:    id = ID22_TPE;
            2, 3:    id = ID22_TIT;
            4:       id = ID22_TAL;
            default: id = {8'h00, rnd_letter(), rnd_letter(), rnd_letter()};
          endcase
        end
        make_text($urandom_range(0, 10), -1);
        if ($urandom_range(0, 15) == 0) data_q.delete();
        add_frame(id, ($urandom_range(0, 11) == 0) ? $urandom_range(1, 60) : 0);
      end
      repeat ($urandom_range(0, 4))
        body_q.push_back(($urandom_range(0, 2) == 0) ? rnd_byte() : 8'h00);
    end

    fsize = body_q.size();
    if (!big && $urandom_range(0, 7) == 0) fsize = $urandom_range(0, fsize + 20);

    file_q.push_back(CH_I);
    file_q.push_back(CH_D);
    file_q.push_back(CH_3);
    file_q.push_back(gen_major[7:0]);
    file_q.push_back(rnd_byte());
    file_q.push_back((rnd_byte() & 8'hBF) | (ext_flag ? 8'h40 : 8'h00));
    // syncsafe size; bit 7 of each byte must be ignored
    for (int i = 3; i >= 0; i--)
      file_q.push_back({($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0, fsize[7*i +: 7]});
    if (!big && $urandom_range(0, 15) == 0) file_q[$urandom_range(0, 2)] = rnd_byte();
    foreach (body_q[i]) file_q.push_back(body_q[i]);
    repeat ($urandom_range(0, 4)) file_q.push_back(rnd_byte());
    if (!big && $urandom_range(0, 7) == 0) begin
      keep = $urandom_range(1, file_q.size());
      while (file_q.size() > keep) void'(file_q.pop_back());
    end
  endtask

  task send_file();
    tx_burst = ($urandom_range(0, 3) == 0);
    rx_burst = ($urandom_range(0, 3) == 0);
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1, 1'b0, 1'b0, '0);
  endtask

  initial begin
    in_bus.valid     = 1'b0;
    in_bus.tag_byte  = 8'h00;
    in_bus.last_byte = 1'b0;
    out_bus.ready    = 1'b0;
    rst_n            = 1'b0;
    n_fail           = 0;
    n_sent           = 0;
    rx_hold          = 0;
    tx_burst         = 1'b0;
    rx_burst         = 1'b0;
    cur_typed        = 1'b0;
    cur_has          = 1'b0;
    cur_res          = '0;
    gen_major        = 0;
    pred             = '0;
    clear_parser();

    // marker, version and early-end cases
    row_exp(8'h00, 1'b1, 1'b1, stop_res(ST_NO_MARKER));
    row_exp(CH_I, 1'b0, 1'b0, '0);
    row_exp(CH_D, 1'b0, 1'b0, '0);
    row_exp(8'h34, 1'b1, 1'b1, stop_res(ST_NO_MARKER));
    row_exp(CH_I, 1'b0, 1'b0, '0);
    row_exp(CH_D, 1'b0, 1'b0, '0);
    row_exp(CH_3, 1'b0, 1'b0, '0);
    row_exp(8'hFF, 1'b1, 1'b1, stop_res(ST_BAD_VERSION));
    row_exp(CH_I, 1'b1, 1'b1, stop_res(ST_EARLY_END));
    // v2.2 tag, one-character title, area runs short straight after it
    row_chk(CH_I, 1'b0);
    row_chk(CH_D, 1'b0);
    row_chk(CH_3, 1'b0);
    row_chk(8'd2, 1'b0);
    row_chk(8'h00, 1'b0);
    row_chk(8'h00, 1'b0);
    row_chk(8'h00, 1'b0);
    row_chk(8'h00, 1'b0);
    row_chk(8'h00, 1'b0);
    row_chk(8'd10, 1'b0);
    row_chk(ID22_TIT[23:16], 1'b0);
    row_chk(ID22_TIT[15:8], 1'b0);
    row_chk(ID22_TIT[7:0], 1'b0);
    row_chk(8'h00, 1'b0);
    row_chk(8'h00, 1'b0);
    row_chk(8'd2, 1'b0);
    row_chk(ENC_LATIN, 1'b0);
    row_chk(CH_Z, 1'b1);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) send_byte(rows[i].b, rows[i].last, rows[i].typed, rows[i].has, rows[i].res);

    // a long raw text runs into the character cap
    build_file(1'b1);
    send_file();
    while (n_sent < SMALL_ITEMS) begin
      build_file(1'b0);
      send_file();
    end
    in_bus.valid <= 1'b0;

    while (text_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_fail == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

>>> sim.f
sv/id3tp_pkg.sv
sv/id3tp_if.sv
sv/id3tp_in_reg.sv
sv/id3tp_core.sv
sv/id3tp_out_reg.sv
sv/id3v2_text_frame_parser.sv
sim/tb_id3v2_text_frame_parser.sv
